// ===== rtl/core/kcc_pkg.sv =====
// ----------------------------------------------------------------------------
// kcc_pkg: shared definitions for the key click classifier
// Action codes, register indexes, reset values and the configuration struct.
// ----------------------------------------------------------------------------
package kcc_pkg;

    // Result codes.
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_SHORT  = 2'd1,
        ACT_LONG   = 2'd2,
        ACT_DOUBLE = 2'd3
    } action_t;

    // Register indexes (byte address divided by four).
    typedef enum logic [1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_LONG     = 2'd1,
        REG_WINDOW   = 2'd2,
        REG_UNUSED   = 2'd3
    } reg_index_t;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [15:0] HELD_LIMIT       = 16'd60000;
    localparam logic [7:0]  DEBOUNCE_RESET   = 8'd3;
    localparam logic [15:0] LONG_RESET       = 16'd100;
    localparam logic [7:0]  WINDOW_RESET     = 8'd30;

    typedef struct packed {
        logic [7:0]  debounce_threshold;
        logic [15:0] long_press_threshold;
        logic [7:0]  double_window;
    } kcc_cfg_t;

endpackage

// ===== rtl/core/kcc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// kcc_cfg_regs: configuration register bank
// Holds the three thresholds behind an APB-style write and read port.
// ----------------------------------------------------------------------------
module kcc_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kcc_pkg::ADDR_W-1:0]    paddr,
    input  logic [kcc_pkg::DATA_W-1:0]    pwdata,
    output logic [kcc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output kcc_pkg::kcc_cfg_t             cfg
);
    import kcc_pkg::*;

    kcc_cfg_t   cfg_reg;
    reg_index_t idx;
    logic       wr_en;

    assign pready = 1'b1;
    assign idx    = reg_index_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_threshold   <= DEBOUNCE_RESET;
            cfg_reg.long_press_threshold <= LONG_RESET;
            cfg_reg.double_window        <= WINDOW_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_DEBOUNCE: cfg_reg.debounce_threshold   <= pwdata[7:0];
                REG_LONG:     cfg_reg.long_press_threshold <= pwdata[15:0];
                REG_WINDOW:   cfg_reg.double_window        <= pwdata[7:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_DEBOUNCE: prdata = {24'd0, cfg_reg.debounce_threshold};
            REG_LONG:     prdata = {16'd0, cfg_reg.long_press_threshold};
            REG_WINDOW:   prdata = {24'd0, cfg_reg.double_window};
            default:      prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/kcc_core.sv =====
// ----------------------------------------------------------------------------
// kcc_core: debounce and click classification state
// Advances the debouncer and classifier by one tick whenever step is high.
// ----------------------------------------------------------------------------
module kcc_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               raw,
    input  kcc_pkg::kcc_cfg_t  cfg,
    output kcc_pkg::action_t   act
);
    import kcc_pkg::*;

    logic        prev_raw_reg,  prev_raw_next;
    logic        stable_reg,    stable_next;
    logic [7:0]  stab_cnt_reg,  stab_cnt_next;
    logic [15:0] held_cnt_reg,  held_cnt_next;
    logic        long_done_reg, long_done_next;
    logic        awaiting_reg,  awaiting_next;
    logic [7:0]  win_cnt_reg,   win_cnt_next;
    logic        skip_rel_reg,  skip_rel_next;

    always_comb
    begin
        prev_raw_next  = prev_raw_reg;
        stable_next    = stable_reg;
        stab_cnt_next  = stab_cnt_reg;
        held_cnt_next  = held_cnt_reg;
        long_done_next = long_done_reg;
        awaiting_next  = awaiting_reg;
        win_cnt_next   = win_cnt_reg;
        skip_rel_next  = skip_rel_reg;
        act            = ACT_NONE;

        // Debounce: count ticks of an unchanged raw level.
        if (raw == prev_raw_reg)
        begin
            if (stab_cnt_reg < cfg.debounce_threshold)
                stab_cnt_next = stab_cnt_reg + 8'd1;
        end
        else
        begin
            prev_raw_next = raw;
            stab_cnt_next = 8'd0;
        end

        // Accepted edge of the debounced level.
        if (stab_cnt_next >= cfg.debounce_threshold && stable_reg != raw)
        begin
            stable_next = raw;
            if (raw)
            begin
                if (awaiting_reg)
                begin
                    awaiting_next  = 1'b0;
                    win_cnt_next   = 8'd0;
                    skip_rel_next  = 1'b1;
                    long_done_next = 1'b1;
                    act            = ACT_DOUBLE;
                end
                else
                begin
                    long_done_next = 1'b0;
                end
            end
            else
            begin
                if (skip_rel_reg)
                    skip_rel_next = 1'b0;
                else if (!long_done_reg && held_cnt_reg != 16'd0)
                begin
                    awaiting_next = 1'b1;
                    win_cnt_next  = 8'd0;
                end
            end
            held_cnt_next = 16'd0;
        end

        // Held timing while pressed.
        if (stable_next)
        begin
            if (held_cnt_next < HELD_LIMIT)
                held_cnt_next = held_cnt_next + 16'd1;
            if (held_cnt_next >= cfg.long_press_threshold && !long_done_next)
            begin
                long_done_next = 1'b1;
                awaiting_next  = 1'b0;
                win_cnt_next   = 8'd0;
                act            = ACT_LONG;
            end
        end

        // Double-click window: a short press is only reported once it expires.
        if (act == ACT_NONE && awaiting_next)
        begin
            if (win_cnt_next < cfg.double_window)
                win_cnt_next = win_cnt_next + 8'd1;
            else
            begin
                awaiting_next = 1'b0;
                win_cnt_next  = 8'd0;
                act           = ACT_SHORT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg  <= 1'b0;
            stable_reg    <= 1'b0;
            stab_cnt_reg  <= 8'd0;
            held_cnt_reg  <= 16'd0;
            long_done_reg <= 1'b0;
            awaiting_reg  <= 1'b0;
            win_cnt_reg   <= 8'd0;
            skip_rel_reg  <= 1'b0;
        end
        else if (step)
        begin
            prev_raw_reg  <= prev_raw_next;
            stable_reg    <= stable_next;
            stab_cnt_reg  <= stab_cnt_next;
            held_cnt_reg  <= held_cnt_next;
            long_done_reg <= long_done_next;
            awaiting_reg  <= awaiting_next;
            win_cnt_reg   <= win_cnt_next;
            skip_rel_reg  <= skip_rel_next;
        end
    end

endmodule

// ===== rtl/core/key_click_classifier.sv =====
// ----------------------------------------------------------------------------
// key_click_classifier: push-button debouncer and click classifier
// Turns one raw key level per tick into one action code per tick.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the input stage register, then moves to the
// result stage register when that stage is free, where its result is presented.
// Throughput: one item per cycle while the consumer does not stall the result
// stage; the limit is the debounce and classifier state update in kcc_core.
// Reset: rst_n is asynchronous and active low; it empties the pipeline, clears
// all classifier state and loads the thresholds with 3, 100 and 30.
// ----------------------------------------------------------------------------
module key_click_classifier
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Input channel: one raw key sample per item.
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          raw_level,
    // Output channel: one action code per item.
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    action,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kcc_pkg::ADDR_W-1:0]    paddr,
    input  logic [kcc_pkg::DATA_W-1:0]    pwdata,
    output logic [kcc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import kcc_pkg::*;

    kcc_cfg_t cfg;
    action_t  core_act;

    // The input stage holds the sampled level; the result stage holds the
    // action code until the consumer takes it.
    logic     in_valid_reg;
    logic     raw_reg;
    logic     out_valid_reg;
    action_t  action_reg;

    logic     res_free;
    logic     step;

    // The result stage can load when it is empty or is being emptied now.
    assign res_free = !out_valid_reg || out_ready;
    // The classifier advances exactly when a sampled item moves to the result.
    assign step     = in_valid_reg && res_free;
    // The input stage takes a new item when it is empty or moving on.
    assign in_ready = !in_valid_reg || res_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (res_free)
                out_valid_reg <= in_valid_reg;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            raw_reg <= raw_level;
        if (step)
            action_reg <= core_act;
    end

    kcc_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kcc_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .raw   (raw_reg),
        .cfg   (cfg),
        .act   (core_act)
    );

    assign out_valid = out_valid_reg;
    assign action    = action_reg;

    // A full input stage behind a stalled result must refuse new items.
    a_no_overrun : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input stage overrun while the result is stalled");

    // Every classifier step produces a result on the next cycle.
    a_step_result : assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid)
        else $error("classifier step without a following result");

    // A double click computed by the classifier is what reaches the port.
    a_double_out : assert property (@(posedge clk) disable iff (!rst_n)
        (step && core_act == ACT_DOUBLE) |=> (action == ACT_DOUBLE))
        else $error("double click lost between classifier and result stage");

endmodule
